@@ rtl/core/nfa_string_acceptor_unit_assert.svh @@
// Assertion macros for the NFA string acceptor checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef NFA_STRING_ACCEPTOR_UNIT_ASSERT_SVH
`define NFA_STRING_ACCEPTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NSA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfa acceptor check failed");

// Next-cycle implication, disabled during reset.
`define NSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfa acceptor check failed");

`endif

@@ rtl/core/nfa_sa_pkg.sv @@
// Shared types and codes for the NFA string acceptor.
// No dependencies.
package nfa_sa_pkg;

    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int FIELD_W   = 4;
    localparam int SYM_IN_W  = 8;
    localparam int ACC_MASK_W = 16;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FEED  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 2'd1;

    // Control of the shared merge unit.
    typedef struct packed {
        logic load;
        logic accum;
        logic gate;
    } nfa_merge_ctl_t;

endpackage

@@ rtl/core/nfa_sa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nfa_sa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/nfa_sa_merge.sv @@
// Shared merge unit: accumulates successor masks by OR into one register.
// Depends on nfa_sa_pkg.
module nfa_sa_merge #(
    parameter int WIDTH = 16
) (
    input  logic                       clk,
    input  nfa_sa_pkg::nfa_merge_ctl_t ctl,
    input  logic [WIDTH-1:0]           load_val,
    input  logic [WIDTH-1:0]           word,
    output logic [WIDTH-1:0]           acc,
    output logic [WIDTH-1:0]           merged
);

    import nfa_sa_pkg::*;

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;

    assign merged = acc_reg | (ctl.gate ? word : '0);
    assign acc    = acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load)
        begin
            acc_next = load_val;
        end
        else if (ctl.accum)
        begin
            acc_next = merged;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

@@ rtl/core/nfa_string_acceptor_unit.sv @@
// NFA string acceptor: transition table in RAM, sequencer steps the state set.
// Depends on nfa_sa_pkg, nfa_sa_ram, nfa_sa_merge.
// Add transition: accept, table read, table write back; in_stall holds off new commands until done.
// Feed symbol: accept, one table read per state, then drain and finish.
// Empty check: accept, then finish; a result waits in an output register.
// After reset the table is swept to zero over all 2^(SYMBOL_BITS+clog2(NUM_STATES)) entries.
module nfa_string_acceptor_unit #(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [nfa_sa_pkg::CMD_W-1:0]         command,
    input  logic [nfa_sa_pkg::FIELD_W-1:0]       from_state,
    input  logic [nfa_sa_pkg::FIELD_W-1:0]       to_state,
    input  logic [nfa_sa_pkg::SYM_IN_W-1:0]      symbol,
    input  logic                                 final_symbol,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 accepted,
    output logic                                 any_active,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nfa_sa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nfa_sa_pkg::CFG_DAT_W-1:0]     cfg_data
);

    import nfa_sa_pkg::*;

    localparam int SW    = $clog2(NUM_STATES);
    localparam int AW    = SYMBOL_BITS + SW;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ADD_RD = 3'd2;
    localparam logic [2:0] S_ADD_WR = 3'd3;
    localparam logic [2:0] S_FEED   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [SW-1:0]          cnt_reg, cnt_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [SW-1:0]          rd_idx_reg, rd_idx_next;
    logic [NUM_STATES-1:0]  active_reg, active_next;
    logic [FIELD_W-1:0]     start_reg, start_next;
    logic [ACC_MASK_W-1:0]  accept_reg, accept_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   accepted_reg, accepted_next;
    logic                   any_active_reg, any_active_next;
    logic [SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic [SW-1:0]          src_reg, src_next;
    logic                   final_reg, final_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [NUM_STATES-1:0]  ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [NUM_STATES-1:0]  ram_rdata;

    nfa_merge_ctl_t         mctl;
    logic [NUM_STATES-1:0]  m_load_val;
    logic [NUM_STATES-1:0]  m_acc;
    logic [NUM_STATES-1:0]  m_merged;

    logic [7:0]             from_ext;
    logic [7:0]             to_ext;
    logic [7:0]             start_ext;
    logic [7:0]             cfg_start_ext;
    logic [63:0]            accept_ext64;
    logic [NUM_STATES-1:0]  accept_set;
    logic [NUM_STATES-1:0]  start_set;
    logic [NUM_STATES-1:0]  cfg_start_set;
    logic                   add_in_range;
    logic                   in_fire;
    logic                   out_free;

    assign in_fire  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !(out_valid_reg && out_stall);

    assign from_ext      = {4'd0, from_state};
    assign to_ext        = {4'd0, to_state};
    assign start_ext     = {4'd0, start_reg};
    assign cfg_start_ext = {4'd0, cfg_data[FIELD_W-1:0]};
    assign add_in_range  = (32'(from_state) < NUM_STATES) && (32'(to_state) < NUM_STATES);

    // States at or above the mask width never accept.
    assign accept_ext64 = {48'd0, accept_reg};
    assign accept_set   = accept_ext64[NUM_STATES-1:0];

    assign start_set     = (32'(start_reg) < NUM_STATES)
                           ? (NUM_STATES'(1) << start_ext[SW-1:0]) : '0;
    assign cfg_start_set = (32'(cfg_data[FIELD_W-1:0]) < NUM_STATES)
                           ? (NUM_STATES'(1) << cfg_start_ext[SW-1:0]) : '0;

    nfa_sa_ram #(
        .WIDTH (NUM_STATES),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nfa_sa_merge #(
        .WIDTH (NUM_STATES)
    ) u_merge (
        .clk      (clk),
        .ctl      (mctl),
        .load_val (m_load_val),
        .word     (ram_rdata),
        .acc      (m_acc),
        .merged   (m_merged)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = rd_pend_reg;
        rd_idx_next     = rd_idx_reg;
        active_next     = active_reg;
        start_next      = start_reg;
        accept_next     = accept_reg;
        out_valid_next  = out_valid_reg;
        accepted_next   = accepted_reg;
        any_active_next = any_active_reg;
        sym_next        = sym_reg;
        src_next        = src_reg;
        final_next      = final_reg;

        ram_we     = 1'b0;
        ram_waddr  = {sym_reg, src_reg};
        ram_wdata  = m_merged;
        ram_raddr  = {sym_reg, src_reg};
        mctl       = '0;
        m_load_val = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    sym_next   = symbol[SYMBOL_BITS-1:0];
                    src_next   = from_ext[SW-1:0];
                    final_next = final_symbol;
                    unique case (command)
                        CMD_ADD:
                        begin
                            if (add_in_range)
                            begin
                                mctl.load  = 1'b1;
                                m_load_val = NUM_STATES'(1) << to_ext[SW-1:0];
                                state_next = S_ADD_RD;
                            end
                        end
                        CMD_FEED:
                        begin
                            mctl.load    = 1'b1;
                            m_load_val   = '0;
                            cnt_next     = '0;
                            rd_pend_next = 1'b0;
                            state_next   = S_FEED;
                        end
                        CMD_EMPTY:
                        begin
                            mctl.load  = 1'b1;
                            m_load_val = start_set;
                            final_next = 1'b1;
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                // write back the old mask with the new target bit
                mctl.gate  = 1'b1;
                ram_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_FEED:
            begin
                ram_raddr    = {sym_reg, cnt_reg};
                mctl.accum   = rd_pend_reg;
                mctl.gate    = active_reg[rd_idx_reg];
                rd_pend_next = 1'b1;
                rd_idx_next  = cnt_reg;
                cnt_next     = cnt_reg + SW'(1);
                if (cnt_reg == SW'(NUM_STATES - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                mctl.accum   = rd_pend_reg;
                mctl.gate    = active_reg[rd_idx_reg];
                rd_pend_next = 1'b0;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (!final_reg)
                begin
                    active_next = m_acc;
                    state_next  = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    accepted_next   = |(m_acc & accept_set);
                    any_active_next = |m_acc;
                    active_next     = start_set;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_START_STATE)
            begin
                start_next  = cfg_data[FIELD_W-1:0];
                active_next = cfg_start_set;
            end
            else if (cfg_index == REG_ACCEPT_MASK)
            begin
                accept_next = cfg_data[ACC_MASK_W-1:0];
            end
        end
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign any_active = any_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            active_reg    <= NUM_STATES'(1);
            start_reg     <= '0;
            accept_reg    <= '0;
            out_valid_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            active_reg    <= active_next;
            start_reg     <= start_next;
            accept_reg    <= accept_next;
            out_valid_reg <= out_valid_next;
            final_reg     <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg   <= accepted_next;
        any_active_reg <= any_active_next;
        sym_reg        <= sym_next;
        src_reg        <= src_next;
    end

endmodule

@@ rtl/core/nfa_sa_checker.sv @@
// Port-level checks for the NFA string acceptor, bound to the top level.
// Depends on nfa_sa_pkg and nfa_string_acceptor_unit_assert.svh.
`include "nfa_string_acceptor_unit_assert.svh"

module nfa_sa_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [nfa_sa_pkg::CMD_W-1:0]     command,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             accepted,
    input logic                             any_active
);

    import nfa_sa_pkg::*;

    // a held result keeps its value
    `NSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({accepted, any_active}))

    // acceptance needs a nonempty state set
    `NSA_ASSERT_IMPL(a_acc_active, out_valid, !accepted || any_active)

    // a fed symbol keeps the block busy while the table is walked
    `NSA_ASSERT_NEXT(a_feed_busy, in_valid && !in_stall && command == CMD_FEED, in_stall)

    // an empty check keeps the block busy for its result step
    `NSA_ASSERT_NEXT(a_empty_busy, in_valid && !in_stall && command == CMD_EMPTY, in_stall)

endmodule

bind nfa_string_acceptor_unit nfa_sa_checker u_nfa_sa_checker (.*);
